// File: rtl/hsl_pkg.sv
// types, constants and helpers shared by the two-wire handshake link
`default_nettype none

package hsl_pkg;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SEND_PREP = 3'd1,
    PH_SENDING   = 3'd2,
    PH_RECV_PREP = 3'd3,
    PH_RECEIVING = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_SEND = 2'd2,
    CMD_RECV = 2'd3
  } cmd_e;

  localparam logic [2:0] STEP_START   = 3'd5;
  localparam logic [2:0] STEP_WAIT_A  = 3'd4;
  localparam logic [2:0] STEP_MID     = 3'd3;
  localparam logic [2:0] STEP_WAIT_B  = 3'd2;
  localparam logic [2:0] STEP_BIT_END = 3'd1;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [1:0] LINES_FREE    = 2'b11;
  localparam logic [1:0] LINES_PULLED  = 2'b00;

  // line view: 1 means the line is free
  function automatic logic [1:0] view_f(input logic [1:0] partner, input logic [1:0] driven);
    view_f = ~(partner | driven);
  endfunction

endpackage

`default_nettype wire

// File: rtl/hsl_fifo.sv
// send byte queue with prefetched head entry
`default_nettype none

module hsl_fifo #(
  parameter int DEPTH = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic [7:0] wdata_i,
  input  wire logic       pop_i,
  output logic      [7:0] head_byte_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    rd_q, byp_data_q;
  logic          byp_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (pop_i) begin
      head_d = (head_q == LAST) ? '0 : head_q + AW'(1);
    end
    if (push_i) begin
      tail_d = (tail_q == LAST) ? '0 : tail_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      byp_q   <= push_i && (tail_q == head_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[tail_q] <= wdata_i;
    end
    rd_q       <= mem[head_d];
    byp_data_q <= wdata_i;
  end

  assign head_byte_o = byp_q ? byp_data_q : rd_q;
  assign empty_o     = (count_q == '0);
  assign full_o      = (count_q == CW'(DEPTH));

endmodule

`default_nettype wire

// File: rtl/two_wire_handshake_link.sv
// top level of the two-wire handshake link, host side
`default_nettype none

// Host side of a two-wire handshake link. Each input beat (tuser = command) is one step of the
// line machine: tick, push a byte into the send queue, start sending or start receiving.
// Every input beat yields exactly one output beat with the line state after that step. A beat is
// taken into an input register and processed combinationally into the output register, so one
// beat per cycle is sustained unless the output stalls. The send queue is a FIFO_DEPTH-entry
// memory whose head entry is prefetched so a pop completes within the step.
module two_wire_handshake_link
  import hsl_pkg::*;
#(
  parameter int FIFO_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] data_byte, [15:8] byte_count, [17:16] partner_lines, [23:18] zero
  input  wire logic [23:0] s_axis_tdata,
  // [1:0] command
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] host_lines, [3:2] line_view, [11:4] byte_out, [12] busy_res, [13] done_res,
  // [14] overflow, [15] zero
  output logic      [15:0] m_axis_tdata,
  // [0] byte_valid
  output logic             m_axis_tuser
);

  // input register
  logic       in_vld_q;
  logic [1:0] in_cmd_q;
  logic [7:0] in_data_q, in_count_q;
  logic [1:0] in_partner_q;

  // output register
  logic        out_vld_q;
  logic [15:0] out_data_q, out_data_d;
  logic        out_user_q, out_user_d;

  // line machine state
  phase_e     phase_q, phase_d;
  logic [2:0] step_q, step_d;
  logic [3:0] bits_q, bits_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] bytes_q, bytes_d;
  logic [1:0] drv_q, drv_d;

  logic       adv;
  logic       push, pop;
  logic       fifo_empty, fifo_full;
  logic [7:0] head_byte;
  logic       done, ovf, bvalid;
  logic [7:0] bout;
  logic [1:0] v;
  logic [2:0] bpos;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    bytes_d = bytes_q;
    drv_d   = drv_q;
    push    = 1'b0;
    pop     = 1'b0;
    done    = 1'b0;
    ovf     = 1'b0;
    bvalid  = 1'b0;
    bout    = '0;
    v       = '0;
    bpos    = '0;

    if (in_cmd_q == CMD_PUSH) begin
      if (fifo_full) begin
        ovf = 1'b1;
      end else begin
        push = 1'b1;
      end
    end else if (in_cmd_q == CMD_SEND && phase_d == PH_IDLE) begin
      if (fifo_empty) begin
        done = 1'b1;
      end else begin
        phase_d = PH_SEND_PREP;
      end
    end else if (in_cmd_q == CMD_RECV && phase_d == PH_IDLE) begin
      if (in_count_q == '0) begin
        done = 1'b1;
      end else begin
        bytes_d = in_count_q;
        phase_d = PH_RECV_PREP;
      end
    end

    if (phase_d == PH_SEND_PREP) begin
      pop     = 1'b1;
      shift_d = head_byte;
      phase_d = PH_SENDING;
      bits_d  = BITS_PER_BYTE;
      step_d  = STEP_START;
    end
    if (phase_d == PH_RECV_PREP && view_f(in_partner_q, drv_d) != LINES_FREE) begin
      phase_d = PH_RECEIVING;
      bits_d  = BITS_PER_BYTE;
      step_d  = STEP_START;
      shift_d = '0;
    end

    if (phase_d == PH_SENDING) begin
      unique case (step_d)
        STEP_START: begin
          drv_d   = {shift_d[0], ~shift_d[0]};
          shift_d = shift_d >> 1;
          step_d  = step_d - 3'd1;
        end
        STEP_WAIT_A: begin
          if (view_f(in_partner_q, drv_d) == LINES_PULLED) begin
            step_d = step_d - 3'd1;
          end
        end
        STEP_MID: begin
          drv_d  = '0;
          step_d = step_d - 3'd1;
        end
        STEP_WAIT_B: begin
          if (view_f(in_partner_q, drv_d) == LINES_FREE) begin
            step_d = step_d - 3'd1;
          end
        end
        STEP_BIT_END: begin
          bits_d = bits_d - 4'd1;
          if (bits_d != '0) begin
            step_d = STEP_START;
          end else if (!fifo_empty || push) begin
            phase_d = PH_SEND_PREP;
          end else begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (phase_d == PH_RECEIVING) begin
      unique case (step_d)
        STEP_START: begin
          v = view_f(in_partner_q, drv_d);
          if (v != LINES_FREE) begin
            bpos    = 3'(BITS_PER_BYTE - bits_d);
            shift_d = shift_d | ({7'd0, v[0]} << bpos);
            step_d  = step_d - 3'd1;
          end
        end
        STEP_WAIT_A: begin
          drv_d  = ~in_partner_q;
          step_d = step_d - 3'd1;
        end
        STEP_MID: begin
          if (in_partner_q == 2'b00) begin
            step_d = step_d - 3'd1;
          end
        end
        STEP_WAIT_B: begin
          drv_d  = '0;
          step_d = step_d - 3'd1;
        end
        STEP_BIT_END: begin
          bits_d = bits_d - 4'd1;
          if (bits_d != '0) begin
            step_d = STEP_START;
          end else begin
            bvalid  = 1'b1;
            bout    = shift_d;
            bytes_d = bytes_d - 8'd1;
            if (bytes_d != '0) begin
              phase_d = PH_RECV_PREP;
            end else begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    out_data_d = {1'b0, ovf, done, (phase_d != PH_IDLE), bout,
                  view_f(in_partner_q, drv_d), drv_d};
    out_user_d = bvalid;
  end

  hsl_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (adv && push),
    .wdata_i    (in_data_q),
    .pop_i      (adv && pop),
    .head_byte_o(head_byte),
    .empty_o    (fifo_empty),
    .full_o     (fifo_full)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PH_IDLE;
      step_q    <= '0;
      bits_q    <= '0;
      shift_q   <= '0;
      bytes_q   <= '0;
      drv_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        phase_q   <= phase_d;
        step_q    <= step_d;
        bits_q    <= bits_d;
        shift_q   <= shift_d;
        bytes_q   <= bytes_d;
        drv_q     <= drv_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q     <= s_axis_tuser;
      in_data_q    <= s_axis_tdata[7:0];
      in_count_q   <= s_axis_tdata[15:8];
      in_partner_q <= s_axis_tdata[17:16];
    end
    if (adv) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire
